>>> hdl/pdp_pkg.sv
// ---------------------------------------------------------------------------
// Position delay predictor package
// Shared widths, register indexes, controller states and the records that
// travel along the history cell chain.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdp_pkg;

    localparam int TIME_W     = 32;
    localparam int POS_W      = 32;
    localparam int DT_W       = 16;
    localparam int DELAY_W    = 16;
    localparam int ERR_W      = 15;
    localparam int PERIOD_W   = 10;
    localparam int PROD_W     = POS_W + DT_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STORE_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DELAY    = 1'd1;

    localparam logic [PERIOD_W-1:0] STORE_PERIOD_RST = 10'd20;
    localparam logic [ERR_W-1:0]    MAX_DELAY_RST    = 15'd500;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_SEARCH
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] n;
        logic [POS_W-1:0] e;
        logic [POS_W-1:0] d;
    } t_delta;

    typedef struct packed {
        logic [ERR_W-1:0] err;
        t_delta           delta;
    } t_match;

    typedef struct packed {
        t_match del;
        t_match cur;
    } t_link;

endpackage

`default_nettype wire

>>> hdl/position_delay_predictor_unit.sv
// ---------------------------------------------------------------------------
// Position delay predictor
// Integrates position deltas, keeps a timestamped history ring and predicts
// the current position from a delayed measurement.
// ---------------------------------------------------------------------------
// An item is taken when start is high and busy is low. An update keeps the
// block busy through its multiply state and then its accumulate state, which
// also stores an entry once the store period has elapsed, and produces no
// result. A query keeps it busy while the best matches walk one history cell
// per cycle down a chain of HIST_DEPTH cells, and its result appears on
// o_strobe in the cycle busy falls. Results are shown for exactly one cycle
// and cannot be held off. History entries are cleared by per-cell valid bits
// at reset, so the block is ready in the first cycle after reset.
// Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module position_delay_predictor_unit #(
    parameter int HIST_DEPTH = 32
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              i_req_type,
    input  wire logic [pdp_pkg::TIME_W-1:0]        i_time_ms,
    input  wire logic signed [pdp_pkg::POS_W-1:0]  i_vel_n,
    input  wire logic signed [pdp_pkg::POS_W-1:0]  i_vel_e,
    input  wire logic signed [pdp_pkg::POS_W-1:0]  i_vel_d,
    input  wire logic [pdp_pkg::DT_W-1:0]          i_step_dt,
    input  wire logic signed [pdp_pkg::POS_W-1:0]  i_meas_n,
    input  wire logic signed [pdp_pkg::POS_W-1:0]  i_meas_e,
    input  wire logic signed [pdp_pkg::POS_W-1:0]  i_meas_d,
    input  wire logic [pdp_pkg::DELAY_W-1:0]       i_delay_ms,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [pdp_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [pdp_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic                                   o_strobe,
    output logic signed [pdp_pkg::POS_W-1:0]       o_pred_n,
    output logic signed [pdp_pkg::POS_W-1:0]       o_pred_e,
    output logic signed [pdp_pkg::POS_W-1:0]       o_pred_d,
    output logic [pdp_pkg::ERR_W-1:0]              o_delay_match_error,
    output logic [pdp_pkg::ERR_W-1:0]              o_current_match_error
);
    import pdp_pkg::*;

    localparam int SLOT_W = $clog2(HIST_DEPTH);
    localparam int CNT_W  = $clog2(HIST_DEPTH + 1);

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_cnt;
    logic [SLOT_W-1:0]   r_slot;
    logic [TIME_W-1:0]   r_last_store;
    logic [PERIOD_W-1:0] r_store_period;
    logic [ERR_W-1:0]    r_max_delay;
    logic                r_strobe;
    logic [TIME_W-1:0]   r_time;
    logic [TIME_W-1:0]   r_tgt_del;
    t_delta              r_meas;
    t_delta              r_pred;
    logic [ERR_W-1:0]    r_err_del;
    logic [ERR_W-1:0]    r_err_cur;

    logic                w_accept;
    logic                w_load_upd;
    logic                w_load_qry;
    logic                w_mul_en;
    logic                w_acc_en;
    logic                w_store;
    logic                w_done;
    logic [TIME_W-1:0]   w_since;
    logic [DELAY_W-1:0]  w_delay_cl;
    t_delta              w_vel;
    t_delta              w_accum_next;
    t_link               w_link [HIST_DEPTH+1];
    logic [HIST_DEPTH-1:0] w_wr_en;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_load_upd  = w_accept && !i_req_type;
    assign w_load_qry  = w_accept && i_req_type;
    assign w_mul_en    = (r_state == S_MUL);
    assign w_acc_en    = (r_state == S_ACC);
    assign w_done      = (r_state == S_SEARCH) && (r_cnt == CNT_W'(HIST_DEPTH));
    assign w_since     = r_time - r_last_store;
    assign w_store     = w_acc_en &&
                         (w_since >= {{(TIME_W-PERIOD_W){1'b0}}, r_store_period});
    assign w_delay_cl  = (i_delay_ms > {1'b0, r_max_delay}) ? {1'b0, r_max_delay}
                                                            : i_delay_ms;

    assign w_vel.n = i_vel_n;
    assign w_vel.e = i_vel_e;
    assign w_vel.d = i_vel_d;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_load_upd) begin
                    n_state = S_MUL;
                end else if (w_load_qry) begin
                    n_state = S_SEARCH;
                end
            end
            S_MUL:    n_state = S_ACC;
            S_ACC:    n_state = S_IDLE;
            S_SEARCH: begin
                if (w_done) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_slot         <= '0;
            r_last_store   <= '0;
            r_store_period <= STORE_PERIOD_RST;
            r_max_delay    <= MAX_DELAY_RST;
            r_strobe       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= w_done;
            if (w_load_qry) begin
                r_cnt <= '0;
            end else if (r_state == S_SEARCH) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (w_store) begin
                r_last_store <= r_time;
                r_slot <= (r_slot == SLOT_W'(HIST_DEPTH - 1)) ? '0 : r_slot + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_STORE_PERIOD: r_store_period <= i_cfg_data[PERIOD_W-1:0];
                    CFG_MAX_DELAY:    r_max_delay    <= i_cfg_data[ERR_W-1:0];
                    default:          ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time <= i_time_ms;
        end
        if (w_load_qry) begin
            r_tgt_del <= i_time_ms - {{(TIME_W-DELAY_W){1'b0}}, w_delay_cl};
            r_meas.n  <= i_meas_n;
            r_meas.e  <= i_meas_e;
            r_meas.d  <= i_meas_d;
        end
        if (w_done) begin
            r_pred.n  <= r_meas.n + w_link[HIST_DEPTH].cur.delta.n
                                  - w_link[HIST_DEPTH].del.delta.n;
            r_pred.e  <= r_meas.e + w_link[HIST_DEPTH].cur.delta.e
                                  - w_link[HIST_DEPTH].del.delta.e;
            r_pred.d  <= r_meas.d + w_link[HIST_DEPTH].cur.delta.d
                                  - w_link[HIST_DEPTH].del.delta.d;
            r_err_del <= w_link[HIST_DEPTH].del.err;
            r_err_cur <= w_link[HIST_DEPTH].cur.err;
        end
    end

    pdp_integ u_integ (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (w_load_upd),
        .i_mul_en     (w_mul_en),
        .i_acc_en     (w_acc_en),
        .i_vel        (w_vel),
        .i_step_dt    (i_step_dt),
        .o_accum_next (w_accum_next)
    );

    assign w_link[0] = '{del: '{err: r_max_delay, delta: '0},
                         cur: '{err: r_max_delay, delta: '0}};

    for (genvar i = 0; i < HIST_DEPTH; i++) begin : g_cell
        assign w_wr_en[i] = w_store && (r_slot == SLOT_W'(i));

        pdp_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_first    (i == 0),
            .i_wr_en    (w_wr_en[i]),
            .i_wr_stamp (r_time),
            .i_wr_delta (w_accum_next),
            .i_tgt_del  (r_tgt_del),
            .i_tgt_cur  (r_time),
            .i_link     (w_link[i]),
            .o_link     (w_link[i+1])
        );
    end

    assign o_strobe              = r_strobe;
    assign o_pred_n              = r_pred.n;
    assign o_pred_e              = r_pred.e;
    assign o_pred_d              = r_pred.d;
    assign o_delay_match_error   = r_err_del;
    assign o_current_match_error = r_err_cur;

endmodule

`default_nettype wire

>>> hdl/pdp_integ.sv
// ---------------------------------------------------------------------------
// Position delta integrator
// Multiplies each velocity axis by the step time, registers the Q16.16 term
// and adds it to the running position delta on the following cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdp_integ (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_load,
    input  wire logic                        i_mul_en,
    input  wire logic                        i_acc_en,
    input  wire pdp_pkg::t_delta             i_vel,
    input  wire logic [pdp_pkg::DT_W-1:0]    i_step_dt,
    output pdp_pkg::t_delta                  o_accum_next
);
    import pdp_pkg::*;

    t_delta                  r_vel;
    logic [DT_W-1:0]         r_dt;
    t_delta                  r_term;
    t_delta                  r_accum;
    logic signed [PROD_W:0]  w_prod_n;
    logic signed [PROD_W:0]  w_prod_e;
    logic signed [PROD_W:0]  w_prod_d;

    always_comb begin
        w_prod_n = $signed(r_vel.n) * $signed({1'b0, r_dt});
        w_prod_e = $signed(r_vel.e) * $signed({1'b0, r_dt});
        w_prod_d = $signed(r_vel.d) * $signed({1'b0, r_dt});
        o_accum_next.n = r_accum.n + r_term.n;
        o_accum_next.e = r_accum.e + r_term.e;
        o_accum_next.d = r_accum.d + r_term.d;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_vel <= i_vel;
            r_dt  <= i_step_dt;
        end
        if (i_mul_en) begin
            r_term.n <= w_prod_n[PROD_W-1:DT_W];
            r_term.e <= w_prod_e[PROD_W-1:DT_W];
            r_term.d <= w_prod_d[PROD_W-1:DT_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
        end else if (i_acc_en) begin
            r_accum <= o_accum_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/pdp_cell.sv
// ---------------------------------------------------------------------------
// History cell
// Holds one timestamped position delta and, every cycle, passes the best
// delayed and current matches seen so far on to the next cell.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdp_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_first,
    input  wire logic                        i_wr_en,
    input  wire logic [pdp_pkg::TIME_W-1:0]  i_wr_stamp,
    input  wire pdp_pkg::t_delta             i_wr_delta,
    input  wire logic [pdp_pkg::TIME_W-1:0]  i_tgt_del,
    input  wire logic [pdp_pkg::TIME_W-1:0]  i_tgt_cur,
    input  wire pdp_pkg::t_link              i_link,
    output pdp_pkg::t_link                   o_link
);
    import pdp_pkg::*;

    logic               r_valid;
    logic [TIME_W-1:0]  r_stamp;
    t_delta             r_delta;
    t_link              r_link;
    t_link              n_link;
    logic [TIME_W-1:0]  w_stamp;
    t_delta             w_delta;
    logic [TIME_W-1:0]  w_diff_del;
    logic [TIME_W-1:0]  w_diff_cur;
    logic [TIME_W-1:0]  w_mag_del;
    logic [TIME_W-1:0]  w_mag_cur;

    always_comb begin
        w_stamp    = r_valid ? r_stamp : '0;
        w_delta    = r_valid ? r_delta : '0;
        w_diff_del = i_tgt_del - w_stamp;
        w_diff_cur = i_tgt_cur - w_stamp;
        w_mag_del  = w_diff_del[TIME_W-1] ? (~w_diff_del + 1'b1) : w_diff_del;
        w_mag_cur  = w_diff_cur[TIME_W-1] ? (~w_diff_cur + 1'b1) : w_diff_cur;

        // The head cell also supplies the fallback entry when nothing matches.
        n_link = i_link;
        if (i_first) begin
            n_link.del.delta = w_delta;
            n_link.cur.delta = w_delta;
        end
        if (w_mag_del < {{(TIME_W-ERR_W){1'b0}}, i_link.del.err}) begin
            n_link.del.err   = w_mag_del[ERR_W-1:0];
            n_link.del.delta = w_delta;
        end
        if (w_mag_cur < {{(TIME_W-ERR_W){1'b0}}, i_link.cur.err}) begin
            n_link.cur.err   = w_mag_cur[ERR_W-1:0];
            n_link.cur.delta = w_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
        if (i_wr_en) begin
            r_stamp <= i_wr_stamp;
            r_delta <= i_wr_delta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid <= 1'b1;
        end
    end

    assign o_link = r_link;

endmodule

`default_nettype wire

>>> hdl/pdp_checker.sv
// ---------------------------------------------------------------------------
// Position delay predictor checker
// Port-level assertions on the command handshake and result strobe, bound to
// the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdp_checker (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    input  wire logic busy,
    input  wire logic i_req_type,
    input  wire logic o_strobe
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_strobe)
        else $error("Block is busy or strobing right after reset.");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("An accepted item did not make the block busy.");

    a_update_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && !i_req_type |=> !o_strobe ##1 !o_strobe ##1 !o_strobe)
        else $error("An update transfer produced a result.");

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("Result strobe while the block is still busy.");

    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("Result strobe held for more than one cycle.");

endmodule

bind position_delay_predictor_unit pdp_checker u_pdp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .start      (start),
    .busy       (busy),
    .i_req_type (i_req_type),
    .o_strobe   (o_strobe)
);

`default_nettype wire
